// ----- hdl/sha512_pkg.sv -----
// Shared types, constants and round functions for the SHA-512 hasher.
package sha512_pkg;

  typedef logic [63:0] word_t;
  typedef word_t vars_t [8];

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN_LO,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  // Control of the message schedule window
  typedef struct packed {
    logic shift;
    logic calc;
  } sched_ctl_t;

  localparam int unsigned NUM_ROUNDS = 80;
  localparam int unsigned RND_W      = $clog2(NUM_ROUNDS);
  localparam logic [RND_W-1:0] LAST_RND = RND_W'(NUM_ROUNDS - 1);

  // Word that carries the lone pad bit after a full final word
  localparam word_t PAD_WORD = 64'h8000_0000_0000_0000;

  localparam vars_t INIT_CHAIN = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam word_t ROUND_K [NUM_ROUNDS] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

endpackage

// ----- hdl/sha512_ifs.sv -----
// Valid/ready channel interfaces for message words and digest words.
interface sha512_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  bytes_valid;
  logic        final_word;

  modport source (output valid, message_word, bytes_valid, final_word, input ready);
  modport sink (input valid, message_word, bytes_valid, final_word, output ready);
endinterface

interface sha512_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic        digest_last;

  modport source (output valid, digest_word, digest_last, input ready);
  modport sink (input valid, digest_word, digest_last, output ready);
endinterface

// ----- hdl/sha512_hash.sv -----
// SHA-512 hasher top level: word intake, padding sequencer, round loop and digest output.
// A word that does not close a 128-byte block is only stored in the schedule window; a word
// that closes one also starts the 80 rounds on the shared round unit and then the chaining add.
// A final word is followed by pad words up to the block end and one or two blocks of rounds,
// then 8 digest words go out, one per cycle while the sink takes them.
// Reset loads the initial chaining values and clears all counters; no clearing pass.
module sha512_hash (
  input  logic                clk,
  input  logic                rst_n,
  sha512_in_if.sink           in_ch,
  sha512_out_if.source        out_ch
);

  localparam logic [3:0] LEN_SLOT = 4'd14;
  localparam logic [3:0] BLK_END  = 4'd15;
  localparam logic [2:0] LAST_IDX = 3'd7;

  sha512_pkg::state_t          state_r, state_nxt;
  logic [3:0]                  fill_r, fill_nxt;
  logic [63:0]                 total_r, total_nxt;
  logic                        pend80_r, pend80_nxt;
  logic                        padding_r, padding_nxt;
  logic                        last_blk_r, last_blk_nxt;
  logic [sha512_pkg::RND_W-1:0] rnd_r, rnd_nxt;
  logic [2:0]                  idx_r, idx_nxt;
  sha512_pkg::vars_t           chain_r, chain_nxt;
  sha512_pkg::vars_t           vars_r, vars_nxt;
  sha512_pkg::vars_t           vars_rnd;

  logic                        in_acc;
  logic                        out_acc;
  logic                        in_rdy;
  logic                        out_vld;
  logic                        push_en;
  logic                        blk_full;
  sha512_pkg::word_t           push_word;
  sha512_pkg::word_t           tail_word;
  sha512_pkg::word_t           w_cur;
  sha512_pkg::sched_ctl_t      sched_ctl;
  logic [3:0]                  nb_eff;

  assign in_acc   = in_ch.valid && (state_r == sha512_pkg::ST_IDLE);
  assign out_acc  = out_ch.ready && (state_r == sha512_pkg::ST_OUT);
  assign blk_full = push_en && (fill_r == BLK_END);
  assign nb_eff   = in_ch.bytes_valid[3] ? 4'd8 : {1'b0, in_ch.bytes_valid[2:0]};

  // Mask a short final word and place the pad byte after its last valid byte
  always_comb begin
    logic [2:0] nb;
    nb = in_ch.bytes_valid[2:0];
    for (int i = 0; i < 8; i++) begin
      if (3'(i) < nb) begin
        tail_word[63-8*i -: 8] = in_ch.message_word[63-8*i -: 8];
      end else if (3'(i) == nb) begin
        tail_word[63-8*i -: 8] = 8'h80;
      end else begin
        tail_word[63-8*i -: 8] = 8'h00;
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha512_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (blk_full) begin
            state_nxt = sha512_pkg::ST_ROUND;
          end else if (in_ch.final_word) begin
            state_nxt = sha512_pkg::ST_PAD;
          end
        end
      end
      sha512_pkg::ST_PAD: begin
        if (blk_full) begin
          state_nxt = sha512_pkg::ST_ROUND;
        end else if (!pend80_r && fill_r == LEN_SLOT) begin
          state_nxt = sha512_pkg::ST_LEN_LO;
        end
      end
      sha512_pkg::ST_LEN_LO: begin
        state_nxt = sha512_pkg::ST_ROUND;
      end
      sha512_pkg::ST_ROUND: begin
        if (rnd_r == sha512_pkg::LAST_RND) begin
          state_nxt = sha512_pkg::ST_ADD;
        end
      end
      sha512_pkg::ST_ADD: begin
        if (last_blk_r) begin
          state_nxt = sha512_pkg::ST_OUT;
        end else if (padding_r) begin
          state_nxt = sha512_pkg::ST_PAD;
        end else begin
          state_nxt = sha512_pkg::ST_IDLE;
        end
      end
      sha512_pkg::ST_OUT: begin
        if (out_acc && idx_r == LAST_IDX) begin
          state_nxt = sha512_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sha512_pkg::ST_IDLE;
    endcase
  end

  // Handshake and word push controls
  always_comb begin
    in_rdy    = 1'b0;
    out_vld   = 1'b0;
    push_en   = 1'b0;
    push_word = '0;
    case (state_r)
      sha512_pkg::ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_ch.valid) begin
          push_en = 1'b1;
          if (in_ch.final_word && !in_ch.bytes_valid[3]) begin
            push_word = tail_word;
          end else begin
            push_word = in_ch.message_word;
          end
        end
      end
      sha512_pkg::ST_PAD: begin
        push_en = 1'b1;
        if (pend80_r) begin
          push_word = sha512_pkg::PAD_WORD;
        end else if (fill_r == LEN_SLOT) begin
          push_word = {61'd0, total_r[63:61]};
        end
      end
      sha512_pkg::ST_LEN_LO: begin
        push_en   = 1'b1;
        push_word = {total_r[60:0], 3'b000};
      end
      sha512_pkg::ST_OUT: begin
        out_vld = 1'b1;
      end
      default: ;
    endcase
  end

  // Datapath and counter next values
  always_comb begin
    fill_nxt     = fill_r;
    total_nxt    = total_r;
    pend80_nxt   = pend80_r;
    padding_nxt  = padding_r;
    last_blk_nxt = last_blk_r;
    rnd_nxt      = rnd_r;
    idx_nxt      = idx_r;
    chain_nxt    = chain_r;
    vars_nxt     = vars_r;

    // Count pushed words; a full block starts the round loop from the chain
    if (push_en) begin
      fill_nxt = fill_r + 4'd1;
    end
    if (blk_full) begin
      vars_nxt = chain_r;
      rnd_nxt  = '0;
    end

    case (state_r)
      sha512_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.final_word) begin
            total_nxt   = total_r + {60'd0, nb_eff};
            padding_nxt = 1'b1;
            pend80_nxt  = in_ch.bytes_valid[3];
          end else begin
            total_nxt = total_r + 64'd8;
          end
        end
      end
      sha512_pkg::ST_PAD: begin
        pend80_nxt = 1'b0;
      end
      sha512_pkg::ST_LEN_LO: begin
        last_blk_nxt = 1'b1;
      end
      sha512_pkg::ST_ROUND: begin
        vars_nxt = vars_rnd;
        rnd_nxt  = rnd_r + 1'b1;
      end
      sha512_pkg::ST_ADD: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + vars_r[i];
        end
      end
      sha512_pkg::ST_OUT: begin
        if (out_acc) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == LAST_IDX) begin
            chain_nxt    = sha512_pkg::INIT_CHAIN;
            total_nxt    = '0;
            padding_nxt  = 1'b0;
            last_blk_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // Hold control state and chain; reset clears the counters and loads the initial chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sha512_pkg::ST_IDLE;
      fill_r     <= '0;
      total_r    <= '0;
      pend80_r   <= 1'b0;
      padding_r  <= 1'b0;
      last_blk_r <= 1'b0;
      rnd_r      <= '0;
      idx_r      <= '0;
      chain_r    <= sha512_pkg::INIT_CHAIN;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      total_r    <= total_nxt;
      pend80_r   <= pend80_nxt;
      padding_r  <= padding_nxt;
      last_blk_r <= last_blk_nxt;
      rnd_r      <= rnd_nxt;
      idx_r      <= idx_nxt;
      chain_r    <= chain_nxt;
    end
  end

  // Working variables need no reset
  always_ff @(posedge clk) begin
    vars_r <= vars_nxt;
  end

  // Shift the window on every push and every round
  assign sched_ctl.shift = push_en || (state_r == sha512_pkg::ST_ROUND);
  assign sched_ctl.calc  = (state_r == sha512_pkg::ST_ROUND);

  sha512_sched u_sched (
    .clk   (clk),
    .ctl   (sched_ctl),
    .din   (push_word),
    .w_cur (w_cur)
  );

  sha512_round u_round (
    .vars_i (vars_r),
    .k      (sha512_pkg::ROUND_K[rnd_r]),
    .w      (w_cur),
    .vars_o (vars_rnd)
  );

  assign in_ch.ready        = in_rdy;
  assign out_ch.valid       = out_vld;
  assign out_ch.digest_word = chain_r[idx_r];
  assign out_ch.digest_last = (idx_r == LAST_IDX);

endmodule

// ----- hdl/sha512_sched.sv -----
// Sixteen-word message schedule window, shifted once per load or round.
module sha512_sched (
  input  logic                   clk,
  input  sha512_pkg::sched_ctl_t ctl,
  input  sha512_pkg::word_t      din,
  output sha512_pkg::word_t      w_cur
);

  sha512_pkg::word_t win_r   [16];
  sha512_pkg::word_t win_nxt [16];
  sha512_pkg::word_t w_calc;

  // Expand the next schedule word from the window
  assign w_calc = sha512_pkg::small_sigma1(win_r[14]) + win_r[9]
                + sha512_pkg::small_sigma0(win_r[1]) + win_r[0];

  // Shift toward the head, append loaded or expanded word
  always_comb begin
    for (int i = 0; i < 15; i++) begin
      win_nxt[i] = win_r[i+1];
    end
    win_nxt[15] = ctl.calc ? w_calc : din;
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      win_r <= win_nxt;
    end
  end

  assign w_cur = win_r[0];

endmodule

// ----- hdl/sha512_round.sv -----
// One SHA-512 compression round over the eight working variables.
module sha512_round (
  input  sha512_pkg::vars_t vars_i,
  input  sha512_pkg::word_t k,
  input  sha512_pkg::word_t w,
  output sha512_pkg::vars_t vars_o
);

  sha512_pkg::word_t ch;
  sha512_pkg::word_t maj;
  sha512_pkg::word_t t1;
  sha512_pkg::word_t t2;

  // Choose and majority terms
  assign ch  = (vars_i[4] & vars_i[5]) ^ (~vars_i[4] & vars_i[6]);
  assign maj = (vars_i[0] & vars_i[1]) ^ (vars_i[0] & vars_i[2]) ^ (vars_i[1] & vars_i[2]);

  assign t1 = vars_i[7] + sha512_pkg::big_sigma1(vars_i[4]) + ch + k + w;
  assign t2 = sha512_pkg::big_sigma0(vars_i[0]) + maj;

  // Rotate variables, inject the new a and e
  always_comb begin
    vars_o[0] = t1 + t2;
    vars_o[1] = vars_i[0];
    vars_o[2] = vars_i[1];
    vars_o[3] = vars_i[2];
    vars_o[4] = vars_i[3] + t1;
    vars_o[5] = vars_i[4];
    vars_o[6] = vars_i[5];
    vars_o[7] = vars_i[6];
  end

endmodule
